// ===== rtl/rsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared types for the replacement selection run generator: transaction
// payloads, stored entry and sequencer states.
// ----------------------------------------------------------------------------
package rsr_pkg;

  typedef struct packed {
    logic [31:0] sort_key;
    logic [31:0] row_number;
    logic        end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_key;
    logic [31:0] out_row;
    logic        run_end;
    logic [31:0] run_length;
    logic        stream_done;
    logic        burst_last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] row;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_EMIT,
    S_WR_M,
    S_WR_LA,
    S_DRAIN
  } st_t;

  localparam logic [31:0] RUN_MAX = 32'hFFFF_FFFF;

endpackage

// ===== rtl/rsr_store.sv =====
// ----------------------------------------------------------------------------
// rsr_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsr_store
  import rsr_pkg::*;
#(
  parameter int HEAP_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(HEAP_ENTRIES)-1:0] wr_addr,
  input  entry_t                          wr_entry,
  input  logic [$clog2(HEAP_ENTRIES)-1:0] rd_addr,
  output entry_t                          rd_entry
);

  entry_t mem [HEAP_ENTRIES];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry_r <= mem[rd_addr];
  end

  assign rd_entry = rd_entry_r;

endmodule

// ===== rtl/replacement_selection_runs.sv =====
// ----------------------------------------------------------------------------
// replacement_selection_runs
// Run generator for external sorting by replacement selection.
// ----------------------------------------------------------------------------
// Entries are kept in a store of HEAP_ENTRIES slots with one write port and one
// registered read port, and one comparator walks the active slots, one per
// cycle, to find the smallest key. A transaction taken while the store is
// filling is written into the next free slot and yields no result unless it
// ends the stream. A transaction taken once the store is full walks the active
// slots through the registered read, then emits the smallest entry; the
// newcomer is written back in the emit when it stays in the run, and through
// S_WR_M and S_WR_LA over the store's single write port when it goes dormant.
// An end-of-stream transaction then drains the store, one emitted entry per
// walk. in_ready is high only between transactions; a finished result waits in
// the output register, and the next emit holds until out_ready frees that
// register.
module replacement_selection_runs
  import rsr_pkg::*;
#(
  parameter int HEAP_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = $clog2(HEAP_ENTRIES);
  localparam int CNT_W = $clog2(HEAP_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(HEAP_ENTRIES);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  st_t              state_r, state_nxt;
  logic [CNT_W-1:0] filled_r, filled_nxt;
  logic [CNT_W-1:0] active_r, active_nxt;
  logic [31:0]      run_count_r, run_count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             rdv_r, rdv_nxt;
  logic [IDX_W-1:0] rdi_r, rdi_nxt;
  logic             drain_r, drain_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  in_item_t         in_r, in_nxt;
  entry_t           best_r, best_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_entry;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry;

  logic [CNT_W-1:0] act_dec;
  logic [CNT_W-1:0] fill_dec;
  logic [IDX_W-1:0] la;
  logic [IDX_W-1:0] lf;
  logic [31:0]      cnt_inc;
  logic             dorm;
  logic             out_free;
  entry_t           in_entry;

  rsr_store #(
    .HEAP_ENTRIES(HEAP_ENTRIES)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  assign act_dec  = active_r - ONE;
  assign fill_dec = filled_r - ONE;
  assign la       = act_dec[IDX_W-1:0];
  assign lf       = fill_dec[IDX_W-1:0];
  assign cnt_inc  = (run_count_r == RUN_MAX) ? RUN_MAX : run_count_r + 32'd1;
  assign dorm     = in_r.sort_key < best_r.key;
  assign out_free = !out_valid_r || out_ready;
  assign in_entry = '{key: in_r.sort_key, row: in_r.row_number};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filled_r    <= '0;
      active_r    <= '0;
      run_count_r <= '0;
      scan_r      <= '0;
      rdv_r       <= 1'b0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      active_r    <= active_nxt;
      run_count_r <= run_count_nxt;
      scan_r      <= scan_nxt;
      rdv_r       <= rdv_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdi_r      <= rdi_nxt;
    out_data_r <= out_data_nxt;
    in_r       <= in_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    active_nxt    = active_r;
    run_count_nxt = run_count_r;
    scan_nxt      = scan_r;
    rdv_nxt       = 1'b0;
    rdi_nxt       = rdi_r;
    drain_nxt     = drain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_nxt        = in_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    wr_en         = 1'b0;
    wr_addr       = best_idx_r;
    wr_entry      = in_entry;
    rd_addr       = la;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt = in_data;
          if (active_r == '0 && filled_r != '0) begin
            active_nxt = filled_r;
          end
          state_nxt = S_START;
        end
      end

      S_START: begin
        drain_nxt = 1'b0;
        if (filled_r < FULL) begin
          wr_en      = 1'b1;
          wr_addr    = filled_r[IDX_W-1:0];
          filled_nxt = filled_r + ONE;
          active_nxt = active_r + ONE;
          state_nxt  = in_r.end_of_stream ? S_DRAIN : S_IDLE;
        end else begin
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_r < active_r) begin
          rd_addr  = scan_r[IDX_W-1:0];
          scan_nxt = scan_r + ONE;
          rdv_nxt  = 1'b1;
          rdi_nxt  = scan_r[IDX_W-1:0];
        end
        if (rdv_r) begin
          if (rdi_r == '0 || rd_entry.key < best_r.key) begin
            best_nxt     = rd_entry;
            best_idx_nxt = rdi_r;
          end
          if (rdi_r == la) begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        rd_addr = la;
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_key     = best_r.key;
          out_data_nxt.out_row     = best_r.row;
          out_data_nxt.run_length  = cnt_inc;
          if (drain_r) begin
            out_data_nxt.run_end     = (active_r == ONE);
            out_data_nxt.stream_done = (filled_r == ONE);
            out_data_nxt.burst_last  = (filled_r == ONE);
            run_count_nxt            = (active_r == ONE) ? '0 : cnt_inc;
            state_nxt                = S_WR_M;
          end else begin
            out_data_nxt.run_end     = dorm && (active_r == ONE);
            out_data_nxt.stream_done = 1'b0;
            out_data_nxt.burst_last  = !in_r.end_of_stream;
            run_count_nxt            = (dorm && (active_r == ONE)) ? '0 : cnt_inc;
            if (dorm) begin
              state_nxt = S_WR_M;
            end else begin
              wr_en     = 1'b1;
              state_nxt = in_r.end_of_stream ? S_DRAIN : S_IDLE;
            end
          end
        end
      end

      S_WR_M: begin
        wr_en     = 1'b1;
        wr_entry  = rd_entry;
        rd_addr   = lf;
        state_nxt = S_WR_LA;
      end

      S_WR_LA: begin
        wr_en   = 1'b1;
        wr_addr = la;
        if (drain_r) begin
          wr_entry = rd_entry;
          if (fill_dec == '0) begin
            filled_nxt = '0;
            active_nxt = '0;
            state_nxt  = S_IDLE;
          end else begin
            filled_nxt = fill_dec;
            active_nxt = (act_dec == '0) ? fill_dec : act_dec;
            state_nxt  = S_DRAIN;
          end
        end else begin
          active_nxt = (act_dec == '0) ? filled_r : act_dec;
          state_nxt  = in_r.end_of_stream ? S_DRAIN : S_IDLE;
        end
      end

      S_DRAIN: begin
        drain_nxt = 1'b1;
        scan_nxt  = '0;
        if (filled_r == '0) begin
          active_nxt    = '0;
          run_count_nxt = '0;
          state_nxt     = S_IDLE;
        end else begin
          if (active_r == '0) begin
            active_nxt = filled_r;
          end
          state_nxt = S_SCAN;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rsr_checker.sv =====
// ----------------------------------------------------------------------------
// rsr_checker
// Port-level checks for the run generator, bound to the top level.
// ----------------------------------------------------------------------------
module rsr_checker
  import rsr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_done |-> out_data.run_end && out_data.burst_last)
    else $error("stream end without run end and burst end");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.run_length != 32'd0)
    else $error("zero run length");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready straight after a transaction");

endmodule

bind replacement_selection_runs rsr_checker u_rsr_checker (.*);
